// ===== sv/rss_pkg.sv =====
// rss_pkg: shared types and constants of the ramp/soak setpoint generator
// used by the channel interfaces, the controller and the datapath
package rss_pkg;

  localparam int CFG_W     = 5;
  localparam int IDXIN_W   = 4;
  localparam int DUR_W     = 16;
  localparam int TEMP_W    = 16;
  localparam int FAN_W     = 7;
  localparam int TIME_W    = 24;
  localparam int SEGNUM_W  = 4;
  localparam int MAG_W     = 16;
  localparam int PROD_W    = 32;
  localparam int NUMER_W   = PROD_W + 1;
  localparam int DIV_STEPS = 16;
  localparam int DIVCNT_W  = $clog2(DIV_STEPS);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [DUR_W-1:0]         dur;
    logic signed [TEMP_W-1:0] temp;
    logic [FAN_W-1:0]         fan;
    logic                     cool;
  } seg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_MUL,
    S_PREP,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic wr;
    logic start;
    logic walk;
    logic mul;
    logic prep;
    logic div;
    logic load;
  } ctl_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic walk_done;
    logic step_case;
    logic div_last;
    logic out_busy;
  } ctl_sts_t;

endpackage

// ===== sv/rss_in_if.sv =====
// rss_in_if: input channel carrying segment writes and setpoint queries
// depends on rss_pkg for field widths
interface rss_in_if import rss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [IDXIN_W-1:0]       entry_index;
  logic [DUR_W-1:0]         entry_duration;
  logic signed [TEMP_W-1:0] entry_temp;
  logic [FAN_W-1:0]         entry_fan;
  logic                     entry_cooling;
  logic [TIME_W-1:0]        elapsed_time;

  modport source (
    output valid, op, entry_index, entry_duration, entry_temp, entry_fan,
           entry_cooling, elapsed_time,
    input  ready
  );

  modport sink (
    input  valid, op, entry_index, entry_duration, entry_temp, entry_fan,
           entry_cooling, elapsed_time,
    output ready
  );
endinterface

// ===== sv/rss_out_if.sv =====
// rss_out_if: result channel carrying one setpoint per query
// depends on rss_pkg for field widths
interface rss_out_if import rss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [SEGNUM_W-1:0]      segment_number;
  logic signed [TEMP_W-1:0] temp_setpoint;
  logic [FAN_W-1:0]         fan_setpoint;
  logic [TIME_W-1:0]        profile_length;

  modport source (
    output valid, segment_number, temp_setpoint, fan_setpoint, profile_length,
    input  ready
  );

  modport sink (
    input  valid, segment_number, temp_setpoint, fan_setpoint, profile_length,
    output ready
  );
endinterface

// ===== sv/rss_ctrl.sv =====
// rss_ctrl: sequencing state machine for table walk, multiply and divide
// depends on rss_pkg for state, command and status types
module rss_ctrl import rss_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   fire;

  assign fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (fire && in_op == OP_QUERY) begin
          state_next = sts.n_zero ? S_FIN : S_WALK;
        end
      end
      S_WALK: begin
        if (sts.walk_done) begin
          state_next = sts.step_case ? S_FIN : S_MUL;
        end
      end
      S_MUL:  state_next = S_PREP;
      S_PREP: state_next = S_DIV;
      S_DIV: begin
        if (sts.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.wr    = fire && in_op == OP_WRITE;
        cmd.start = fire && in_op == OP_QUERY;
      end
      S_WALK: cmd.walk = 1'b1;
      S_MUL:  cmd.mul  = 1'b1;
      S_PREP: cmd.prep = 1'b1;
      S_DIV:  cmd.div  = 1'b1;
      S_FIN:  cmd.load = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/rss_datapath.sv =====
// rss_datapath: segment memory, walk accumulators, ramp multiply, serial divider
// and result register; depends on rss_pkg, driven by rss_ctrl commands
module rss_datapath import rss_pkg::*; #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ctl_cmd_t                 cmd,
  output ctl_sts_t                 sts,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic [IDXIN_W-1:0]       entry_index,
  input  logic [DUR_W-1:0]         entry_duration,
  input  logic signed [TEMP_W-1:0] entry_temp,
  input  logic [FAN_W-1:0]         entry_fan,
  input  logic                     entry_cooling,
  input  logic [TIME_W-1:0]        elapsed_time,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [SEGNUM_W-1:0]      segment_number,
  output logic signed [TEMP_W-1:0] temp_setpoint,
  output logic [FAN_W-1:0]         fan_setpoint,
  output logic [TIME_W-1:0]        profile_length
);

  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  // configuration
  logic [CFG_W-1:0] seg_count;
  logic [CNT_W-1:0] n_live;

  // segment memory
  seg_t             mem [MAX_SEGMENTS];
  seg_t             wr_entry;
  logic [IDX_W-1:0] wr_addr;
  logic             slot_ok;
  seg_t             rd_data;
  logic             rd_en;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] rd_cnt;
  logic             rd_last;

  // walk state
  logic [TIME_W-1:0]        t_reg;
  logic [TIME_W-1:0]        cursor;
  logic [TIME_W-1:0]        seg_end;
  logic [TIME_W-1:0]        total;
  logic [TIME_W-1:0]        start;
  logic                     found;
  logic                     walk_done;
  logic                     empty;
  logic [IDX_W-1:0]         idx;
  logic signed [TEMP_W-1:0] to_temp;
  logic signed [TEMP_W-1:0] from_temp;
  logic signed [TEMP_W-1:0] prev_temp;
  logic [DUR_W-1:0]         dur_r;
  logic [FAN_W-1:0]         fan_r;
  logic                     cool_r;

  // ramp arithmetic
  logic signed [TEMP_W:0] delta;
  logic [TEMP_W:0]        delta_abs;
  logic [TIME_W-1:0]      diff;
  logic [DUR_W-1:0]       num;
  logic [PROD_W-1:0]      prod;
  logic                   neg_r;
  logic [NUMER_W-1:0]     numer;
  logic [DUR_W:0]         divisor;
  logic [DUR_W:0]         rem;
  logic [DUR_W+1:0]       trial;
  logic                   qbit;
  logic [MAG_W-1:0]       qsh;
  logic [DIVCNT_W-1:0]    div_cnt;
  logic [TEMP_W-1:0]      res;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count <= '0;
    end else if (cfg_we) begin
      seg_count <= cfg_wdata;
    end
  end

  always_comb begin
    if (int'(seg_count) > MAX_SEGMENTS) begin
      n_live = CNT_W'(MAX_SEGMENTS);
    end else begin
      n_live = CNT_W'(seg_count);
    end
  end

  assign wr_entry = '{dur: entry_duration, temp: entry_temp, fan: entry_fan,
                      cool: entry_cooling};
  assign wr_addr  = IDX_W'(entry_index);
  assign slot_ok  = int'(entry_index) < MAX_SEGMENTS;

  always_ff @(posedge clk) begin
    if (cmd.wr && slot_ok) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  assign rd_en = cmd.walk && (rd_cnt < n_live);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_cnt[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      rd_cnt   <= '0;
    end else begin
      rd_valid <= rd_en;
      if (cmd.start) begin
        rd_cnt <= '0;
      end else if (rd_en) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx <= rd_cnt[IDX_W-1:0];
    end
  end

  assign rd_last = CNT_W'(rd_idx) == n_live - CNT_W'(1);
  assign seg_end = cursor + TIME_W'(rd_data.dur);

  function automatic logic elapsed_lt_end();
    return t_reg < seg_end;
  endfunction

  // walk: sum every duration, stop the cursor at the first segment that holds t or at the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_done <= 1'b0;
      found     <= 1'b0;
      empty     <= 1'b0;
    end else if (cmd.start) begin
      walk_done <= 1'b0;
      found     <= 1'b0;
      empty     <= n_live == '0;
    end else if (rd_valid) begin
      if (rd_last) begin
        walk_done <= 1'b1;
      end
      if (!found && (elapsed_lt_end() || rd_last)) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      t_reg  <= elapsed_time;
      cursor <= '0;
      total  <= '0;
    end else if (rd_valid) begin
      total     <= total + TIME_W'(rd_data.dur);
      prev_temp <= rd_data.temp;
      if (!found) begin
        if (elapsed_lt_end() || rd_last) begin
          idx       <= rd_idx;
          start     <= cursor;
          to_temp   <= rd_data.temp;
          from_temp <= prev_temp;
          dur_r     <= rd_data.dur;
          fan_r     <= rd_data.fan;
          cool_r    <= rd_data.cool;
        end else begin
          cursor <= seg_end;
        end
      end
    end
  end

  // ramp: |to - from| * min(t - start, dur)
  assign delta     = {to_temp[TEMP_W-1], to_temp} - {from_temp[TEMP_W-1], from_temp};
  assign delta_abs = delta[TEMP_W] ? (TEMP_W+1)'(-delta) : delta;
  assign diff      = t_reg - start;
  assign num       = (diff > TIME_W'(dur_r)) ? dur_r : diff[DUR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod  <= delta_abs[MAG_W-1:0] * num;
      neg_r <= delta[TEMP_W];
    end
  end

  // rounded quotient (2*prod + dur) / (2*dur), one bit per cycle
  assign numer   = {prod, 1'b0} + NUMER_W'(dur_r);
  assign divisor = {dur_r, 1'b0};
  assign trial   = {rem, qsh[MAG_W-1]};
  assign qbit    = trial >= (DUR_W+2)'(divisor);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      rem     <= numer[NUMER_W-1:MAG_W];
      qsh     <= numer[MAG_W-1:0];
      div_cnt <= '0;
    end else if (cmd.div) begin
      rem     <= qbit ? (DUR_W+1)'(trial - (DUR_W+2)'(divisor)) : trial[DUR_W:0];
      qsh     <= {qsh[MAG_W-2:0], qbit};
      div_cnt <= div_cnt + DIVCNT_W'(1);
    end
  end

  always_comb begin
    if (sts.step_case) begin
      res = to_temp;
    end else if (neg_r) begin
      res = from_temp - qsh;
    end else begin
      res = from_temp + qsh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (empty) begin
        segment_number <= '0;
        temp_setpoint  <= '0;
        fan_setpoint   <= '0;
        profile_length <= '0;
      end else begin
        segment_number <= SEGNUM_W'(idx);
        temp_setpoint  <= res;
        fan_setpoint   <= fan_r;
        profile_length <= total;
      end
    end
  end

  assign sts.n_zero    = n_live == '0;
  assign sts.walk_done = walk_done;
  assign sts.step_case = (idx == '0) || cool_r || (dur_r == '0);
  assign sts.div_last  = div_cnt == DIVCNT_W'(DIV_STEPS - 1);
  assign sts.out_busy  = out_valid && !out_ready;

endmodule

// ===== sv/ramp_soak_setpoint_generator_unit.sv =====
// ramp/soak setpoint generator: one query or table write per item
// write items are taken in the idle state; a query that steps runs the table walk
// and then loads its result, and a query that ramps runs the table walk, multiply,
// divide set-up and 16-step divide before the load; a query on an empty profile goes straight to the load
// one item in flight at a time; the table walk and the divide set the rate, and a
// result not yet taken holds off the next one; reset clears the segment count and
// all control, the segment table is undefined until written
module ramp_soak_setpoint_generator_unit import rss_pkg::*; #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  rss_in_if.sink           req,
  rss_out_if.source        rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  rss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_op    (req.op),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rss_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .entry_index    (req.entry_index),
    .entry_duration (req.entry_duration),
    .entry_temp     (req.entry_temp),
    .entry_fan      (req.entry_fan),
    .entry_cooling  (req.entry_cooling),
    .elapsed_time   (req.elapsed_time),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .segment_number (rsp.segment_number),
    .temp_setpoint  (rsp.temp_setpoint),
    .fan_setpoint   (rsp.fan_setpoint),
    .profile_length (rsp.profile_length)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// testbench for ramp_soak_setpoint_generator_unit: loads segment tables, sweeps
// queries over them and checks every setpoint against an in-file profile predictor
// depends on rss_pkg and the rss_in_if / rss_out_if channel interfaces
module testbench;
  import rss_pkg::*;

  localparam int MAX_SEG = 16;
  localparam int QUERY_LATENCY = 64;
  localparam int IDLE_PCT = 29;
  localparam int ITEM_TARGET = 1350;

  typedef struct packed {
    logic                     op;
    logic [IDXIN_W-1:0]       entry_idx;
    logic [DUR_W-1:0]         dur;
    logic signed [TEMP_W-1:0] temp;
    logic [FAN_W-1:0]         fan;
    logic                     cool;
    logic [TIME_W-1:0]        t;
  } profile_item_t;

  localparam int ITEM_W = $bits(profile_item_t);

  typedef struct packed {
    logic [SEGNUM_W-1:0]      seg;
    logic signed [TEMP_W-1:0] temp;
    logic [FAN_W-1:0]         fan;
    logic [TIME_W-1:0]        length;
  } setpoint_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  rss_in_if  req_if ();
  rss_out_if rsp_if ();

  ramp_soak_setpoint_generator_unit #(.MAX_SEGMENTS(MAX_SEG)) dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state: profile table and segment count as the block should hold them
  seg_t             profile_tbl [MAX_SEG];
  logic [CFG_W-1:0] seg_count = '0;
  setpoint_t        pending_setpoints [$];

  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned hold_off = 0;
  bit          no_gaps = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned live_segments();
    return (seg_count > MAX_SEG) ? MAX_SEG : seg_count;
  endfunction

  function automatic int unsigned profile_total();
    int unsigned sum;
    sum = 0;
    for (int i = 0; i < live_segments(); i++) sum += profile_tbl[i].dur;
    return (sum > 32'hFF_FFFF) ? 32'hFF_FFFF : sum;
  endfunction

  function automatic setpoint_t setpoint_for(input logic [TIME_W-1:0] t);
    setpoint_t        r;
    int unsigned      n, cursor, start, fin, num, dur;
    int               idx, to_t, from_t, delta, res;
    longint unsigned  mag, q;
    r = '0;
    n = live_segments();
    if (n == 0) return r;
    idx = 0;
    cursor = 0;
    start = 0;
    // walk to the segment holding t, clamping to the last one
    for (int i = 0; i < n; i++) begin
      fin = cursor + profile_tbl[i].dur;
      idx = i;
      start = cursor;
      if (t < fin || i == n - 1) break;
      cursor = fin;
    end
    to_t = $signed(profile_tbl[idx].temp);
    dur = profile_tbl[idx].dur;
    if (idx == 0 || profile_tbl[idx].cool || dur == 0) begin
      res = to_t;
    end else begin
      num = t - start;
      if (num > dur) num = dur;
      from_t = $signed(profile_tbl[idx-1].temp);
      delta = to_t - from_t;
      mag = (delta < 0) ? longint'(-delta) : longint'(delta);
      // round half away from zero on the magnitude
      q = (64'd2 * mag * num + dur) / (64'd2 * dur);
      res = (delta < 0) ? from_t - int'(q) : from_t + int'(q);
    end
    r.seg = idx[SEGNUM_W-1:0];
    r.temp = res[TEMP_W-1:0];
    r.fan = profile_tbl[idx].fan;
    r.length = profile_total();
    return r;
  endfunction

  // elapsed times: mostly inside the profile, many on segment edges, some anywhere
  function automatic logic [TIME_W-1:0] pick_time();
    int unsigned       n, total, edge_at, k, sel;
    logic [TIME_W-1:0] t;
    n = live_segments();
    total = profile_total();
    sel = $urandom_range(99);
    if (sel < 10) begin
      t = TIME_W'($urandom());
    end else if (sel < 45 && n > 0) begin
      k = $urandom_range(n - 1);
      edge_at = 0;
      for (int i = 0; i <= k; i++) edge_at += profile_tbl[i].dur;
      if (edge_at == 0) t = TIME_W'($urandom_range(1));
      else t = TIME_W'(edge_at - 1 + $urandom_range(2));
    end else begin
      t = TIME_W'($urandom_range(total + total / 8 + 2));
    end
    return t;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch at result %0d: %s got %0h expected %0h",
             results_seen, what, got, want);
  endtask

  task automatic send_item(input profile_item_t it);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid          <= 1'b1;
    req_if.op             <= it.op;
    req_if.entry_index    <= it.entry_idx;
    req_if.entry_duration <= it.dur;
    req_if.entry_temp     <= it.temp;
    req_if.entry_fan      <= it.fan;
    req_if.entry_cooling  <= it.cool;
    req_if.elapsed_time   <= it.t;
    do @(posedge clk); while (!req_if.ready);
    if (it.op == OP_WRITE)
      profile_tbl[it.entry_idx] = '{dur: it.dur, temp: it.temp, fan: it.fan, cool: it.cool};
    else
      pending_setpoints.push_back(setpoint_for(it.t));
    items_sent++;
  endtask

  task automatic write_item(input int entry, input logic [DUR_W-1:0] dur,
                            input logic [TEMP_W-1:0] temp, input logic [FAN_W-1:0] fan,
                            input logic cool);
    profile_item_t it;
    it.op = OP_WRITE;
    it.entry_idx = IDXIN_W'(entry);
    it.dur = dur;
    it.temp = temp;
    it.fan = fan;
    it.cool = cool;
    it.t = TIME_W'($urandom());
    send_item(it);
  endtask

  task automatic query_item(input logic [TIME_W-1:0] t);
    profile_item_t it;
    it = ITEM_W'({$urandom(), $urandom(), $urandom()});
    it.op = OP_QUERY;
    it.t = t;
    send_item(it);
  endtask

  task automatic write_random_segment(input int entry);
    logic [DUR_W-1:0]  dur;
    logic [TEMP_W-1:0] temp;
    int unsigned       sel;
    sel = $urandom_range(99);
    if (sel < 10) dur = 0;
    else if (sel < 60) dur = DUR_W'($urandom_range(1, 20));
    else if (sel < 90) dur = DUR_W'($urandom_range(21, 1000));
    else dur = DUR_W'($urandom());
    sel = $urandom_range(99);
    if (sel < 7) temp = 16'h8000;
    else if (sel < 14) temp = 16'h7FFF;
    else if (sel < 20) temp = 16'h0000;
    else temp = TEMP_W'($urandom());
    write_item(entry, dur, temp,
               FAN_W'(($urandom_range(99) < 85) ? $urandom_range(100)
                                                 : $urandom_range(101, 127)),
               $urandom_range(99) < 20);
  endtask

  // idle the request side until every setpoint is back and the block has settled
  task automatic wait_drain();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_setpoints.size() != 0) @(negedge clk);
    repeat (QUERY_LATENCY) @(negedge clk);
  endtask

  task automatic set_segment_count(input logic [CFG_W-1:0] value);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    seg_count = value;
  endtask

  task automatic run_profile_phase(input logic [CFG_W-1:0] count, input int queries);
    set_segment_count(count);
    repeat ($urandom_range(16)) write_random_segment($urandom_range(MAX_SEG - 1));
    repeat (queries) begin
      // a few stray table writes land between queries
      if ($urandom_range(99) < 8) write_random_segment($urandom_range(MAX_SEG - 1));
      else query_item(pick_time());
    end
  endtask

  task automatic test_empty_profile();
    query_item('0);
    query_item('1);
  endtask

  task automatic test_table_load();
    write_item(0, 10, 16'h8000, 0, 1'b0);      // first segment steps
    write_item(1, 2, 16'h7FFF, 100, 1'b0);     // full-scale ramp up, half-way tie
    write_item(2, 5, 16'h0000, 50, 1'b1);      // cooling step
    write_item(3, 0, 16'd101, 127, 1'b0);      // zero-length step, fan above 100
    write_item(4, 2, 16'h8000, 1, 1'b0);       // ramp down, negative tie
    write_item(5, 16'hFFFF, 16'h7FFF, 64, 1'b0);
    for (int i = 6; i < MAX_SEG; i++)
      write_item(i, DUR_W'(i + 1), TEMP_W'(i * 1000 - 8000), FAN_W'(i * 6), i[0]);
  endtask

  task automatic test_directed_queries();
    set_segment_count(5'd31);   // above the table size, acts as a full table
    query_item(24'd0);
    query_item(24'd11);
    query_item(24'd12);
    query_item(24'd17);
    query_item(24'd18);
    query_item(24'hFF_FFFF);
    set_segment_count(5'd1);
    query_item(24'hFF_FFFF);
  endtask

  task automatic test_output_stall();
    set_segment_count(5'd16);
    hold_off = 400;
    repeat (30) query_item(pick_time());
    wait_drain();
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    run_profile_phase(5'd16, 60);
    run_profile_phase(5'd0, 10);
    run_profile_phase(5'd9, 60);
    no_gaps = 1'b0;
  endtask

  task automatic test_random_profiles();
    int unsigned      sel;
    logic [CFG_W-1:0] count;
    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(99);
      if (sel < 5) count = 0;
      else if (sel < 12) count = CFG_W'($urandom_range(17, 31));
      else if (sel < 25) count = 16;
      else if (sel < 32) count = 1;
      else count = CFG_W'($urandom_range(2, 15));
      run_profile_phase(count, $urandom_range(10, 40));
    end
  endtask

  always @(negedge clk) begin
    if (hold_off > 0) begin
      rsp_if.ready <= 1'b0;
      hold_off--;
    end else begin
      rsp_if.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    setpoint_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_setpoints.size() == 0) begin
        report_mismatch("result with no query pending", 0, 0);
      end else begin
        want = pending_setpoints.pop_front();
        if (rsp_if.segment_number !== want.seg)
          report_mismatch("segment_number", 32'(rsp_if.segment_number), 32'(want.seg));
        if (rsp_if.temp_setpoint !== want.temp)
          report_mismatch("temp_setpoint", 32'(rsp_if.temp_setpoint), 32'(want.temp));
        if (rsp_if.fan_setpoint !== want.fan)
          report_mismatch("fan_setpoint", 32'(rsp_if.fan_setpoint), 32'(want.fan));
        if (rsp_if.profile_length !== want.length)
          report_mismatch("profile_length", 32'(rsp_if.profile_length),
                          32'(want.length));
      end
      results_seen++;
    end
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    for (int i = 0; i < MAX_SEG; i++) profile_tbl[i] = '0;
    req_if.valid = 1'b0;
    req_if.op = OP_WRITE;
    req_if.entry_index = '0;
    req_if.entry_duration = '0;
    req_if.entry_temp = '0;
    req_if.entry_fan = '0;
    req_if.entry_cooling = 1'b0;
    req_if.elapsed_time = '0;
    rsp_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_profile();
    test_table_load();
    test_directed_queries();
    test_output_stall();
    test_back_to_back();
    test_random_profiles();
    wait_drain();
    if (mismatches == 0 && pending_setpoints.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
